// ===== rtl/fel_pkg.sv =====
// fel_pkg: shared types and constants of the formatting element list
// holds opcodes, status codes, default sizes and the cell control structs
// no dependencies
`default_nettype none

package fel_pkg;

  // default sizes
  localparam int unsigned DefListDepth     = 16;
  localparam int unsigned DefElementIdBits = 16;
  localparam int unsigned DefTagIdBits     = 8;

  localparam int unsigned OpcodeW = 4;
  localparam int unsigned StatusW = 2;

  typedef enum logic [OpcodeW-1:0] {
    OP_ADD        = 4'd0,
    OP_MARKER     = 4'd1,
    OP_CONTAINS   = 4'd2,
    OP_TAG_SEARCH = 4'd3,
    OP_REMOVE     = 4'd4,
    OP_CLEAR      = 4'd5,
    OP_FIND       = 4'd6,
    OP_REPLACE    = 4'd7,
    OP_INSERT     = 4'd8
  } fel_op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } fel_status_e;

  // per-beat write controls broadcast to every cell
  typedef struct packed {
    logic append;       // write new entry at the tail
    logic append_mark;  // the appended entry is a marker
    logic insert;       // insert at position, shift upper entries up
    logic remove;       // close up over the first match
    logic replace;      // overwrite every match
  } fel_ctl_t;

  // priority chain running from the tail down to entry 0
  typedef struct packed {
    logic tag_done;   // tag search stopped at a higher entry
    logic mark_seen;  // a marker is held at a higher entry
  } fel_bwd_t;

endpackage

`default_nettype wire

// ===== rtl/formatting_element_list_core.sv =====
// formatting_element_list_core: top level of the formatting element list
// depends on fel_pkg and fel_cell
//
//   channel  direction  handshake                  payload
//   in       input      in_valid_i / in_ready_o    opcode, ids, tags, position
//   out      output     out_valid_o / out_ready_i  status, found, ids, count
//
// one operation per cycle unless a held result stalls the input: every cell
// compares its entry in the same cycle and priority chains ripple along the row
// of cells, so any opcode completes at the accepting edge and its result sits in
// the output register, ready to be taken in the cycle after the input beat
// the output register frees itself in the cycle it is taken, so in_ready_o is
// low only while a result is held and out_ready_i is low
// reset clears the entry count and the output valid; entry contents are not
// reset and are only read below the count
`default_nettype none

module formatting_element_list_core #(
  parameter int unsigned LIST_DEPTH      = fel_pkg::DefListDepth,
  parameter int unsigned ELEMENT_ID_BITS = fel_pkg::DefElementIdBits,
  parameter int unsigned TAG_ID_BITS     = fel_pkg::DefTagIdBits
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  // input beat
  input  wire                                  in_valid_i,
  output logic                                 in_ready_o,
  input  wire  [fel_pkg::OpcodeW-1:0]          opcode_i,
  input  wire  [ELEMENT_ID_BITS-1:0]           element_id_i,
  input  wire  [TAG_ID_BITS-1:0]               tag_id_i,
  input  wire  [ELEMENT_ID_BITS-1:0]           new_element_id_i,
  input  wire  [TAG_ID_BITS-1:0]               new_tag_id_i,
  input  wire  [$clog2(LIST_DEPTH+1)-1:0]      position_i,
  // result beat
  output logic                                 out_valid_o,
  input  wire                                  out_ready_i,
  output logic [fel_pkg::StatusW-1:0]          status_o,
  output logic                                 found_o,
  output logic [ELEMENT_ID_BITS-1:0]           found_element_id_o,
  output logic [$clog2(LIST_DEPTH)-1:0]        found_index_o,
  output logic [$clog2(LIST_DEPTH+1)-1:0]      entry_count_o
);

  localparam int unsigned CntW = $clog2(LIST_DEPTH + 1);
  localparam int unsigned IdxW = $clog2(LIST_DEPTH);
  localparam logic [CntW-1:0] FullCnt = CntW'(LIST_DEPTH);

  fel_pkg::fel_op_e   op;
  fel_pkg::fel_ctl_t  ctl;
  logic               step;
  logic               full;
  logic               pos_bad;

  logic [CntW-1:0]    count_q, count_d;

  // row of cells
  logic [ELEMENT_ID_BITS-1:0] cell_elem [LIST_DEPTH];
  logic [TAG_ID_BITS-1:0]     cell_tag  [LIST_DEPTH];
  logic                       cell_mark [LIST_DEPTH];
  logic [LIST_DEPTH:0]        seen;
  fel_pkg::fel_bwd_t          bwd [LIST_DEPTH+1];
  logic [LIST_DEPTH-1:0]      first;
  logic [LIST_DEPTH-1:0]      hit;
  logic [LIST_DEPTH-1:0]      last_mark;

  // gathered results
  logic                       contains;
  logic                       tag_hit;
  logic [ELEMENT_ID_BITS-1:0] hit_elem;
  logic [IdxW-1:0]            first_idx;
  logic [CntW-1:0]            mark_idx;

  // output register
  logic                       out_valid_q;
  fel_pkg::fel_status_e       status_q, status_d;
  logic                       found_q, found_d;
  logic [ELEMENT_ID_BITS-1:0] fel_q, fel_d;
  logic [IdxW-1:0]            fidx_q, fidx_d;
  logic [CntW-1:0]            cnt_out_q;

  assign op         = fel_pkg::fel_op_e'(opcode_i);
  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign step       = in_valid_i & in_ready_o;
  assign full       = count_q == FullCnt;
  assign pos_bad    = position_i > count_q;

  // write controls for the cells, only on an accepted beat
  always_comb begin
    ctl = '0;
    ctl.append_mark = op == fel_pkg::OP_MARKER;
    if (step) begin
      case (op)
        fel_pkg::OP_ADD,
        fel_pkg::OP_MARKER:  ctl.append  = ~full;
        fel_pkg::OP_INSERT:  ctl.insert  = ~pos_bad & ~full;
        fel_pkg::OP_REMOVE:  ctl.remove  = 1'b1;
        fel_pkg::OP_REPLACE: ctl.replace = 1'b1;
        default: ;
      endcase
    end
  end

  assign seen[0]         = 1'b0;
  assign bwd[LIST_DEPTH] = '0;

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    localparam int unsigned Lo = (i == 0) ? 0 : i - 1;
    localparam int unsigned Hi = (i == LIST_DEPTH - 1) ? i : i + 1;

    fel_cell #(
      .INDEX (i),
      .DEPTH (LIST_DEPTH),
      .ELEM_W(ELEMENT_ID_BITS),
      .TAG_W (TAG_ID_BITS),
      .CNT_W (CntW)
    ) u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl),
      .elem_i     (element_id_i),
      .tag_i      (tag_id_i),
      .nelem_i    (new_element_id_i),
      .ntag_i     (new_tag_id_i),
      .pos_i      (position_i),
      .count_i    (count_q),
      .lo_elem_i  (cell_elem[Lo]),
      .lo_tag_i   (cell_tag[Lo]),
      .lo_mark_i  (cell_mark[Lo]),
      .hi_elem_i  (cell_elem[Hi]),
      .hi_tag_i   (cell_tag[Hi]),
      .hi_mark_i  (cell_mark[Hi]),
      .elem_o     (cell_elem[i]),
      .tag_o      (cell_tag[i]),
      .mark_o     (cell_mark[i]),
      .seen_i     (seen[i]),
      .seen_o     (seen[i+1]),
      .bwd_i      (bwd[i+1]),
      .bwd_o      (bwd[i]),
      .first_o    (first[i]),
      .hit_o      (hit[i]),
      .last_mark_o(last_mark[i])
    );
  end

  assign contains = seen[LIST_DEPTH];
  assign tag_hit  = |hit;

  // at most one cell raises each flag, so the results are plain or-trees
  always_comb begin
    hit_elem  = '0;
    first_idx = '0;
    mark_idx  = '0;
    for (int unsigned k = 0; k < LIST_DEPTH; k++) begin
      hit_elem  = hit_elem  | (hit[k]       ? cell_elem[k] : '0);
      first_idx = first_idx | (first[k]     ? IdxW'(k)     : '0);
      mark_idx  = mark_idx  | (last_mark[k] ? CntW'(k)     : '0);
    end
  end

  // next count and result fields
  always_comb begin
    count_d  = count_q;
    status_d = fel_pkg::ST_OK;
    found_d  = 1'b0;
    fel_d    = '0;
    fidx_d   = '0;
    case (op)
      fel_pkg::OP_ADD,
      fel_pkg::OP_MARKER: begin
        if (full) begin
          status_d = fel_pkg::ST_FULL;
        end else begin
          count_d = count_q + CntW'(1);
        end
      end
      fel_pkg::OP_CONTAINS: begin
        found_d = contains;
      end
      fel_pkg::OP_TAG_SEARCH: begin
        found_d = tag_hit;
        fel_d   = hit_elem;
      end
      fel_pkg::OP_REMOVE: begin
        if (contains) begin
          count_d = count_q - CntW'(1);
        end
      end
      fel_pkg::OP_CLEAR: begin
        // pops through the last marker, or everything when none is held
        count_d = mark_idx;
      end
      fel_pkg::OP_FIND: begin
        found_d = contains;
        fidx_d  = first_idx;
      end
      fel_pkg::OP_INSERT: begin
        if (pos_bad) begin
          status_d = fel_pkg::ST_RANGE;
        end else if (full) begin
          status_d = fel_pkg::ST_FULL;
        end else begin
          count_d = count_q + CntW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (step) begin
        count_q <= count_d;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, loaded with each accepted beat
  always_ff @(posedge clk_i) begin
    if (step) begin
      status_q  <= status_d;
      found_q   <= found_d;
      fel_q     <= fel_d;
      fidx_q    <= fidx_d;
      cnt_out_q <= count_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = status_q;
  assign found_o            = found_q;
  assign found_element_id_o = fel_q;
  assign found_index_o      = fidx_q;
  assign entry_count_o      = cnt_out_q;

endmodule

`default_nettype wire

// ===== rtl/fel_cell.sv =====
// fel_cell: one list entry with its compare logic and neighbor shift
// depends on fel_pkg for the control and chain structs
`default_nettype none

module fel_cell #(
  parameter int unsigned INDEX    = 0,
  parameter int unsigned DEPTH    = fel_pkg::DefListDepth,
  parameter int unsigned ELEM_W   = fel_pkg::DefElementIdBits,
  parameter int unsigned TAG_W    = fel_pkg::DefTagIdBits,
  parameter int unsigned CNT_W    = $clog2(DEPTH + 1)
) (
  input  wire                   clk_i,
  input  wire fel_pkg::fel_ctl_t ctl_i,
  input  wire  [ELEM_W-1:0]     elem_i,
  input  wire  [TAG_W-1:0]      tag_i,
  input  wire  [ELEM_W-1:0]     nelem_i,
  input  wire  [TAG_W-1:0]      ntag_i,
  input  wire  [CNT_W-1:0]      pos_i,
  input  wire  [CNT_W-1:0]      count_i,
  // lower neighbor entry
  input  wire  [ELEM_W-1:0]     lo_elem_i,
  input  wire  [TAG_W-1:0]      lo_tag_i,
  input  wire                   lo_mark_i,
  // upper neighbor entry
  input  wire  [ELEM_W-1:0]     hi_elem_i,
  input  wire  [TAG_W-1:0]      hi_tag_i,
  input  wire                   hi_mark_i,
  // own entry
  output logic [ELEM_W-1:0]     elem_o,
  output logic [TAG_W-1:0]      tag_o,
  output logic                  mark_o,
  // match chain from entry 0 upward
  input  wire                   seen_i,
  output logic                  seen_o,
  // chain from the tail downward
  input  wire fel_pkg::fel_bwd_t bwd_i,
  output fel_pkg::fel_bwd_t     bwd_o,
  // per-entry results
  output logic                  first_o,
  output logic                  hit_o,
  output logic                  last_mark_o
);

  localparam logic [CNT_W-1:0] MyIdx = CNT_W'(INDEX);

  logic [ELEM_W-1:0] elem_q, elem_d;
  logic [TAG_W-1:0]  tag_q, tag_d;
  logic              mark_q, mark_d;
  logic              occ;
  logic              match;
  logic              tag_eq;

  assign occ    = MyIdx < count_i;
  assign match  = occ && !mark_q && (elem_q == elem_i);
  assign tag_eq = tag_q == tag_i;

  assign seen_o  = seen_i | match;
  assign first_o = match & ~seen_i;

  // tag search walks down from the tail, a marker or a tag hit ends it
  assign hit_o              = occ && !bwd_i.tag_done && !mark_q && tag_eq;
  assign bwd_o.tag_done     = bwd_i.tag_done | (occ & (mark_q | tag_eq));
  assign last_mark_o        = occ && mark_q && !bwd_i.mark_seen;
  assign bwd_o.mark_seen    = bwd_i.mark_seen | (occ & mark_q);

  always_comb begin
    elem_d = elem_q;
    tag_d  = tag_q;
    mark_d = mark_q;
    if (ctl_i.append && (MyIdx == count_i)) begin
      elem_d = ctl_i.append_mark ? '0 : elem_i;
      tag_d  = ctl_i.append_mark ? '0 : tag_i;
      mark_d = ctl_i.append_mark;
    end else if (ctl_i.insert) begin
      if (MyIdx == pos_i) begin
        elem_d = elem_i;
        tag_d  = tag_i;
        mark_d = 1'b0;
      end else if (MyIdx > pos_i) begin
        elem_d = lo_elem_i;
        tag_d  = lo_tag_i;
        mark_d = lo_mark_i;
      end
    end else if (ctl_i.remove && seen_o) begin
      elem_d = hi_elem_i;
      tag_d  = hi_tag_i;
      mark_d = hi_mark_i;
    end else if (ctl_i.replace && match) begin
      elem_d = nelem_i;
      tag_d  = ntag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    elem_q <= elem_d;
    tag_q  <= tag_d;
    mark_q <= mark_d;
  end

  assign elem_o = elem_q;
  assign tag_o  = tag_q;
  assign mark_o = mark_q;

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// tb_top: self-checking bench for formatting_element_list_core
// drives directed and random list operations, predicts every result beat with an
// in-bench list model and compares field by field; depends on fel_pkg and the core
module tb_top;

  localparam int unsigned Depth  = fel_pkg::DefListDepth;
  localparam int unsigned ElemW  = fel_pkg::DefElementIdBits;
  localparam int unsigned TagW   = fel_pkg::DefTagIdBits;
  localparam int unsigned OpW    = fel_pkg::OpcodeW;
  localparam int unsigned StW    = fel_pkg::StatusW;
  localparam int unsigned CountW = $clog2(Depth + 1);
  localparam int unsigned IndexW = $clog2(Depth);
  localparam int unsigned RandomOps = 550;

  // one list operation as queued for the driver
  typedef struct packed {
    logic [OpW-1:0]     op;
    logic [ElemW-1:0]   elem;
    logic [TagW-1:0]    tag;
    logic [ElemW-1:0]   new_elem;
    logic [TagW-1:0]    new_tag;
    logic [CountW-1:0]  pos;
    logic [7:0]         gap;    // idle cycles before the beat is offered
    logic               drain;  // hold until every awaited result is in
  } list_op_t;

  typedef struct packed {
    logic [StW-1:0]     status;
    logic               found;
    logic [ElemW-1:0]   found_elem;
    logic [IndexW-1:0]  found_idx;
    logic [CountW-1:0]  count;
  } list_result_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [OpW-1:0]     op_r = '0;
  logic [ElemW-1:0]   elem_r = '0;
  logic [TagW-1:0]    tag_r = '0;
  logic [ElemW-1:0]   new_elem_r = '0;
  logic [TagW-1:0]    new_tag_r = '0;
  logic [CountW-1:0]  pos_r = '0;

  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [StW-1:0]     status_w;
  logic               found_w;
  logic [ElemW-1:0]   found_elem_w;
  logic [IndexW-1:0]  found_idx_w;
  logic [CountW-1:0]  count_w;

  formatting_element_list_core DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .opcode_i           (op_r),
    .element_id_i       (elem_r),
    .tag_id_i           (tag_r),
    .new_element_id_i   (new_elem_r),
    .new_tag_id_i       (new_tag_r),
    .position_i         (pos_r),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .status_o           (status_w),
    .found_o            (found_w),
    .found_element_id_o (found_elem_w),
    .found_index_o      (found_idx_w),
    .entry_count_o      (count_w)
  );

  // list model state, owned by the driver process
  logic [ElemW-1:0] list_elem [Depth];
  logic [TagW-1:0]  list_tag  [Depth];
  bit               list_mark [Depth];
  int               held_n = 0;

  list_op_t     op_queue[$];
  list_result_t awaited_results[$];

  int issued_n  = 0;  // beats accepted on the input side
  int retired_n = 0;  // result beats taken on the output side
  int errors    = 0;

  // generator controls
  bit quiet_gaps = 1'b0;
  bit drain_next = 1'b0;

  // driver and monitor scratch
  list_op_t     cur_op;
  list_op_t     next_op;
  list_result_t want;
  logic         drv_busy;
  logic         drv_took;
  logic         drv_hold;
  int           idle_cycles = 0;
  int           stall_left = 0;
  int           cycle_n = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // ---------------------------------------------------------------- list model

  // markers never count as a match
  function automatic bit holds_elem(int idx, logic [ElemW-1:0] id);
    return !list_mark[idx] && list_elem[idx] == id;
  endfunction

  function automatic list_result_t apply_list_op(list_op_t c);
    list_result_t r;
    int i;
    int hit;
    r = '0;
    hit = -1;
    case (c.op)
      fel_pkg::OP_ADD, fel_pkg::OP_MARKER: begin
        if (held_n >= Depth) begin
          r.status = fel_pkg::ST_FULL;
        end else begin
          list_elem[held_n] = (c.op == fel_pkg::OP_ADD) ? c.elem : '0;
          list_tag[held_n]  = (c.op == fel_pkg::OP_ADD) ? c.tag : '0;
          list_mark[held_n] = (c.op == fel_pkg::OP_MARKER);
          held_n++;
        end
      end
      fel_pkg::OP_CONTAINS: begin
        for (i = 0; i < held_n; i++)
          if (holds_elem(i, c.elem)) r.found = 1'b1;
      end
      fel_pkg::OP_TAG_SEARCH: begin
        // walk back from the tail, a marker ends the search
        for (i = held_n - 1; i >= 0; i--) begin
          if (list_mark[i]) break;
          if (list_tag[i] == c.tag) begin
            r.found      = 1'b1;
            r.found_elem = list_elem[i];
            break;
          end
        end
      end
      fel_pkg::OP_REMOVE: begin
        for (i = 0; i < held_n; i++)
          if (hit < 0 && holds_elem(i, c.elem)) hit = i;
        if (hit >= 0) begin
          for (i = hit; i < held_n - 1; i++) begin
            list_elem[i] = list_elem[i + 1];
            list_tag[i]  = list_tag[i + 1];
            list_mark[i] = list_mark[i + 1];
          end
          held_n--;
        end
      end
      fel_pkg::OP_CLEAR: begin
        while (held_n > 0) begin
          held_n--;
          if (list_mark[held_n]) break;
        end
      end
      fel_pkg::OP_FIND: begin
        for (i = 0; i < held_n; i++)
          if (!r.found && holds_elem(i, c.elem)) begin
            r.found     = 1'b1;
            r.found_idx = IndexW'(i);
          end
      end
      fel_pkg::OP_REPLACE: begin
        for (i = 0; i < held_n; i++)
          if (holds_elem(i, c.elem)) begin
            list_elem[i] = c.new_elem;
            list_tag[i]  = c.new_tag;
          end
      end
      fel_pkg::OP_INSERT: begin
        // range check ranks above the full check
        if (int'(c.pos) > held_n) begin
          r.status = fel_pkg::ST_RANGE;
        end else if (held_n >= Depth) begin
          r.status = fel_pkg::ST_FULL;
        end else begin
          for (i = held_n; i > int'(c.pos); i--) begin
            list_elem[i] = list_elem[i - 1];
            list_tag[i]  = list_tag[i - 1];
            list_mark[i] = list_mark[i - 1];
          end
          list_elem[c.pos] = c.elem;
          list_tag[c.pos]  = c.tag;
          list_mark[c.pos] = 1'b0;
          held_n++;
        end
      end
      default: ;
    endcase
    r.count = CountW'(held_n);
    return r;
  endfunction

  // ---------------------------------------------------------------- driver

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid    <= 1'b0;
      issued_n    <= 0;
      idle_cycles = 0;
    end else begin
      drv_busy = in_valid;
      drv_took = in_valid && in_ready;
      if (drv_took) begin
        awaited_results.push_back(apply_list_op(cur_op));
        issued_n <= issued_n + 1;
        drv_busy = 1'b0;
      end
      if (!drv_busy && op_queue.size() != 0) begin
        next_op  = op_queue[0];
        // a drain beat waits until the result side has caught up
        drv_hold = next_op.drain && (drv_took || retired_n != issued_n);
        if (!drv_hold) begin
          if (idle_cycles < int'(next_op.gap)) begin
            idle_cycles++;
          end else begin
            cur_op      = op_queue.pop_front();
            idle_cycles = 0;
            drv_busy    = 1'b1;
            op_r       <= cur_op.op;
            elem_r     <= cur_op.elem;
            tag_r      <= cur_op.tag;
            new_elem_r <= cur_op.new_elem;
            new_tag_r  <= cur_op.new_tag;
            pos_r      <= cur_op.pos;
          end
        end
      end
      in_valid <= drv_busy;
    end
  end

  // ---------------------------------------------------------------- monitor

  task automatic check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
      errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready  <= 1'b0;
      retired_n  <= 0;
      stall_left = 0;
      cycle_n    = 0;
    end else begin
      cycle_n++;
      if (out_valid && out_ready) begin
        retired_n <= retired_n + 1;
        if (awaited_results.size() == 0) begin
          $display("%0t: result beat with nothing awaited, count %0d", $time, count_w);
          errors++;
        end else begin
          want = awaited_results.pop_front();
          check_field("status", 32'(want.status), 32'(status_w));
          check_field("found", 32'(want.found), 32'(found_w));
          check_field("found_element_id", 32'(want.found_elem), 32'(found_elem_w));
          check_field("found_index", 32'(want.found_idx), 32'(found_idx_w));
          check_field("entry_count", 32'(want.count), 32'(count_w));
        end
      end
      // one window in four starts no new stalls, so ready stays high once a running stall ends
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if ((cycle_n / 300) % 4 != 1 && $urandom_range(0, 99) < 20) begin
        stall_left = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 2)
                                                  : $urandom_range(8, 30);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // a small pool of ids keeps hits frequent for find, remove and replace
  function automatic logic [ElemW-1:0] pick_elem();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return ElemW'(16'h1234);
      3: return ElemW'(16'h00a5);
      4: return ElemW'(16'h8001);
      5: return ElemW'(16'h5a5a);
      default: return ElemW'($urandom_range(0, (1 << ElemW) - 1));
    endcase
  endfunction

  function automatic logic [TagW-1:0] pick_tag();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return TagW'(8'h03);
      3: return TagW'(8'h7a);
      default: return TagW'($urandom_range(0, (1 << TagW) - 1));
    endcase
  endfunction

  function automatic logic [CountW-1:0] pick_pos();
    if ($urandom_range(0, 99) < 85) return CountW'($urandom_range(0, Depth));
    return CountW'($urandom_range(Depth + 1, (1 << CountW) - 1));
  endfunction

  // mode 0 grows the list, mode 2 shrinks it, mode 1 mixes everything
  function automatic logic [OpW-1:0] pick_op(int mode);
    int r;
    r = $urandom_range(0, 99);
    if (mode == 0) r = r / 2;
    else if (mode == 2) r = 50 + r / 2;
    if (r < 20) return fel_pkg::OP_ADD;
    if (r < 32) return fel_pkg::OP_INSERT;
    if (r < 38) return fel_pkg::OP_MARKER;
    if (r < 46) return fel_pkg::OP_CONTAINS;
    if (r < 56) return fel_pkg::OP_TAG_SEARCH;
    if (r < 64) return fel_pkg::OP_FIND;
    if (r < 71) return fel_pkg::OP_REPLACE;
    if (r < 74) return OpW'($urandom_range(fel_pkg::OP_INSERT + 1, (1 << OpW) - 1));
    if (r < 89) return fel_pkg::OP_REMOVE;
    return fel_pkg::OP_CLEAR;
  endfunction

  task automatic push_op(logic [OpW-1:0] op, logic [ElemW-1:0] elem,
                         logic [TagW-1:0] tag, logic [ElemW-1:0] new_elem,
                         logic [TagW-1:0] new_tag, logic [CountW-1:0] pos);
    list_op_t c;
    c.op       = op;
    c.elem     = elem;
    c.tag      = tag;
    c.new_elem = new_elem;
    c.new_tag  = new_tag;
    c.pos      = pos;
    c.gap      = quiet_gaps ? 8'd0 : 8'(pick_gap());
    c.drain    = drain_next;
    drain_next = 1'b0;
    op_queue.push_back(c);
  endtask

  initial begin
    int n;
    int mode;

    // empty list corner cases
    push_op(fel_pkg::OP_CONTAINS, '0, '0, '0, '0, '0);
    push_op(fel_pkg::OP_TAG_SEARCH, '0, '0, '0, '0, '0);
    push_op(fel_pkg::OP_CLEAR, '0, '0, '0, '0, '0);
    push_op(fel_pkg::OP_INSERT, '0, '0, '0, '0, CountW'(1));
    // build [ffff, 0000, marker, 1234]
    push_op(fel_pkg::OP_INSERT, '1, '1, '0, '0, '0);
    push_op(fel_pkg::OP_ADD, '0, '0, '0, '0, '0);
    push_op(fel_pkg::OP_MARKER, '1, '1, '1, '1, '1);
    push_op(fel_pkg::OP_ADD, ElemW'(16'h1234), '1, '0, '0, '0);
    push_op(fel_pkg::OP_TAG_SEARCH, '0, '1, '0, '0, '0);
    // tag 0 sits below the marker, so the search stops short
    push_op(fel_pkg::OP_TAG_SEARCH, '0, '0, '0, '0, '0);
    push_op(fel_pkg::OP_FIND, '0, '0, '0, '0, '0);
    push_op(fel_pkg::OP_REMOVE, '0, '0, '0, '0, '0);
    // the marker holds id 0 but must not match
    push_op(fel_pkg::OP_CONTAINS, '0, '0, '0, '0, '0);
    push_op(fel_pkg::OP_FIND, '0, '0, '0, '0, '0);
    push_op(fel_pkg::OP_REPLACE, ElemW'(16'h1234), '0, '1, TagW'(8'h7a), '0);
    push_op(fel_pkg::OP_REPLACE, '1, '0, ElemW'(16'h0bee), '0, '0);
    push_op(fel_pkg::OP_REMOVE, ElemW'(16'h5555), '0, '0, '0, '0);
    push_op(fel_pkg::OP_INSERT, '0, '0, '0, '0, '1);
    push_op(OpW'((1 << OpW) - 1), '1, '1, '1, '1, '1);
    push_op(fel_pkg::OP_CLEAR, '0, '0, '0, '0, '0);
    push_op(fel_pkg::OP_CLEAR, '0, '0, '0, '0, '0);
    // fill to the top, then hit every full and range case
    for (n = 0; n < Depth; n++)
      push_op(fel_pkg::OP_ADD, ElemW'(16'h0100 + n), TagW'(n), '0, '0, '0);
    push_op(fel_pkg::OP_ADD, '1, '1, '0, '0, '0);
    push_op(fel_pkg::OP_MARKER, '0, '0, '0, '0, '0);
    push_op(fel_pkg::OP_INSERT, '1, '1, '0, '0, CountW'(Depth));
    push_op(fel_pkg::OP_INSERT, '1, '1, '0, '0, CountW'(Depth + 1));
    push_op(fel_pkg::OP_FIND, ElemW'(16'h0100 + Depth - 1), '0, '0, '0, '0);
    push_op(fel_pkg::OP_TAG_SEARCH, '0, '0, '0, '0, '0);
    push_op(fel_pkg::OP_CLEAR, '0, '0, '0, '0, '0);

    // random part in blocks with their own bias and idling style
    mode = 1;
    for (n = 0; n < RandomOps; n++) begin
      if (n % 50 == 0) begin
        mode       = $urandom_range(0, 2);
        quiet_gaps = ($urandom_range(0, 3) == 0);
      end
      if (n == 0 || $urandom_range(0, 99) == 0) drain_next = 1'b1;
      push_op(pick_op(mode), pick_elem(), pick_tag(), pick_elem(), pick_tag(), pick_pos());
    end

    wait (rst_ni === 1'b1);
    while (op_queue.size() != 0 || in_valid || retired_n != issued_n) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (awaited_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, awaited_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("formatting_element_list_core verification clean");
    end else begin
      $display("formatting_element_list_core verification failed");
    end
    $finish;
  end

  // watchdog, far above the slowest legal run
  initial begin
    #2000000;
    $display("formatting_element_list_core verification failed");
    $finish;
  end

endmodule
